[rtl/lpg_pkg.sv]
// shared constants and types of the line pixel generator
package lpg_pkg;

   // image size registers
   localparam int DIM_BITS = 7;
   localparam logic [DIM_BITS-1:0] DIM_RESET = 7'd64;

   typedef logic [DIM_BITS-1:0] dim_type;
   typedef logic [0:0]          csr_addr_type;

   // register indexes
   localparam csr_addr_type REG_IMAGE_WIDTH  = 1'b0;
   localparam csr_addr_type REG_IMAGE_HEIGHT = 1'b1;

endpackage

[rtl/line_pixel_generator_top.sv]
// line pixel generator: walks a line between two endpoints, one pixel per transfer
//
// Usage:
//   req channel: one transfer carries a line request (start point, end point, color).
//   rsp channel: n+1 pixel transfers follow, n being the longer of |dx| and |dy|;
//   tlast marks the final pixel, which is always the end point, and tuser carries
//   the visible flag (pixel inside the image width and height registers).
//   csr port: write enable, index 0 image width, index 1 image height; write only
//   while no line is in progress.
// Sequence:
//   a request passes through an accept (idle) state and a setup state; the emit
//   state then offers the pixels in turn, stepping only on a pixel transfer. Each
//   pixel after the first comes from one pass of the shared add/compare step unit
//   (remainder accumulate against n). rsp_tvalid rises when the setup state that
//   follows the request transfer gives way to the emit state. req_tready is high
//   only while no line is in progress.
// Reset:
//   synchronous; the block returns to idle, drops rsp_tvalid and both image size
//   registers return to 64.
// Stall:
//   while rsp_tready is low the current pixel is held unchanged and stepping stops.
module line_pixel_generator_top #(
   parameter int COORD_BITS = 6
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, end_x, end_y, pixel_color, zero fill
   input  logic [((4*COORD_BITS+32+7)/8)*8-1:0] req_tdata,
   // result channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_x, pixel_y, out_color, zero fill
   output logic [((2*COORD_BITS+32+7)/8)*8-1:0] rsp_tdata,
   // visible
   output logic rsp_tuser,
   output logic rsp_tlast,
   // configuration port
   input  logic                  csr_wen,
   input  lpg_pkg::csr_addr_type csr_addr,
   input  lpg_pkg::dim_type      csr_wdata
);
   import lpg_pkg::*;

   localparam int RSP_W = ((2*COORD_BITS+32+7)/8)*8;
   localparam int CMP_W = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int C     = COORD_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0] state_ff, state_in;

   // latched request
   logic [C-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [31:0]  color_ff;

   // walk control
   logic         y_major_ff, y_major_in;
   logic         dmin_neg_ff, dmin_neg_in;
   logic         dmaj_neg_ff, dmaj_neg_in;
   logic [C-1:0] n_ff, n_in;
   logic [C-1:0] adm_ff, adm_in;
   logic [C-1:0] k_ff, k_in;
   logic [C-1:0] r_ff, r_in;
   logic [C-1:0] minor_ff, minor_in;
   logic [C-1:0] major_ff, major_in;
   logic         last_ff, last_in;

   // image size registers
   dim_type width_ff, height_ff;

   // setup arithmetic
   logic signed [C:0] dx, dy;
   logic [C-1:0]      adx, ady;
   logic              y_major_set;

   // step unit
   logic [C:0]   r_sum;
   logic         carry;
   logic [C-1:0] k_next;

   logic         rsp_xfer;
   logic [C-1:0] pix_x, pix_y;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // deltas and major axis choice
   always_comb begin
      dx  = $signed({1'b0, ex_ff}) - $signed({1'b0, sx_ff});
      dy  = $signed({1'b0, ey_ff}) - $signed({1'b0, sy_ff});
      adx = dx[C] ? C'(-dx) : C'(dx);
      ady = dy[C] ? C'(-dy) : C'(dy);
      y_major_set = ady > adx;
   end

   // remainder accumulate: floor(k*|dmin|/n) advances by at most one per step
   always_comb begin
      r_sum  = {1'b0, r_ff} + {1'b0, adm_ff};
      carry  = r_sum >= {1'b0, n_ff};
      k_next = k_ff + 1'b1;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      y_major_in  = y_major_ff;
      dmin_neg_in = dmin_neg_ff;
      dmaj_neg_in = dmaj_neg_ff;
      n_in        = n_ff;
      adm_in      = adm_ff;
      k_in        = k_ff;
      r_in        = r_ff;
      minor_in    = minor_ff;
      major_in    = major_ff;
      last_in     = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            y_major_in  = y_major_set;
            n_in        = y_major_set ? ady : adx;
            adm_in      = y_major_set ? adx : ady;
            dmin_neg_in = y_major_set ? dx[C] : dy[C];
            dmaj_neg_in = y_major_set ? dy[C] : dx[C];
            minor_in    = y_major_set ? sx_ff : sy_ff;
            major_in    = y_major_set ? sy_ff : sx_ff;
            k_in        = '0;
            r_in        = '0;
            last_in     = (y_major_set ? ady : adx) == '0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_next;
                  r_in     = carry ? C'(r_sum - {1'b0, n_ff}) : C'(r_sum);
                  if (carry) begin
                     minor_in = dmin_neg_ff ? minor_ff - 1'b1 : minor_ff + 1'b1;
                  end
                  major_in = dmaj_neg_ff ? major_ff - 1'b1 : major_ff + 1'b1;
                  last_in  = (k_next == n_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // walk datapath registers
   always_ff @(posedge clock) begin
      y_major_ff  <= y_major_in;
      dmin_neg_ff <= dmin_neg_in;
      dmaj_neg_ff <= dmaj_neg_in;
      n_ff        <= n_in;
      adm_ff      <= adm_in;
      k_ff        <= k_in;
      r_ff        <= r_in;
      minor_ff    <= minor_in;
      major_ff    <= major_in;
      last_ff     <= last_in;
   end

   // request latch on transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sx_ff    <= req_tdata[C-1:0];
         sy_ff    <= req_tdata[2*C-1:C];
         ex_ff    <= req_tdata[3*C-1:2*C];
         ey_ff    <= req_tdata[4*C-1:3*C];
         color_ff <= req_tdata[4*C+31:4*C];
      end
   end

   // image size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // result packing
   assign pix_x     = y_major_ff ? minor_ff : major_ff;
   assign pix_y     = y_major_ff ? major_ff : minor_ff;
   assign rsp_tdata = RSP_W'({color_ff, pix_y, pix_x});
   assign rsp_tlast = last_ff;
   assign rsp_tuser = (CMP_W'(pix_x) < CMP_W'(width_ff)) &&
                      (CMP_W'(pix_y) < CMP_W'(height_ff));

endmodule

[rtl/lpg_checker.sv]
// port-level checks of the line pixel generator and their bind
module lpg_checker #(
   parameter int COORD_BITS = 6
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2*COORD_BITS+32+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tlast
);

   // stalled pixel holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled pixel changed");

   // no request taken while pixels are pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request ready while a pixel is offered");

   // a request transfer makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after request transfer");

   // final pixel transfer returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not idle after final pixel");

   // more pixels follow a non-final transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("line ended without final pixel");

endmodule

bind line_pixel_generator_top lpg_checker #(.COORD_BITS(COORD_BITS)) u_lpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
